FILE: rtl/core/rtc_bnr_pkg.sv
// Shared types, register map codes and digit helpers for the banked
// nibble RTC register file. No dependencies.
`timescale 1ns / 1ps

package rtc_bnr_pkg;

  // Sequencer states: wait for an access, wait for RAM data, hold the result
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_OUT
  } state_e;

  // Bus access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Bank select codes from the mode register
  localparam logic [1:0] BANK_TIME    = 2'd0;
  localparam logic [1:0] BANK_ALARM   = 2'd1;
  localparam logic [1:0] BANK_SCR_LO  = 2'd2;
  localparam logic [1:0] BANK_SCR_HI  = 2'd3;

  // Time bank register map
  localparam logic [3:0] ADDR_SEC_ONES  = 4'd0;
  localparam logic [3:0] ADDR_SEC_TENS  = 4'd1;
  localparam logic [3:0] ADDR_MIN_ONES  = 4'd2;
  localparam logic [3:0] ADDR_MIN_TENS  = 4'd3;
  localparam logic [3:0] ADDR_HR_ONES   = 4'd4;
  localparam logic [3:0] ADDR_HR_TENS   = 4'd5;
  localparam logic [3:0] ADDR_WEEKDAY   = 4'd6;
  localparam logic [3:0] ADDR_DAY_ONES  = 4'd7;
  localparam logic [3:0] ADDR_DAY_TENS  = 4'd8;
  localparam logic [3:0] ADDR_MON_ONES  = 4'd9;
  localparam logic [3:0] ADDR_MON_TENS  = 4'd10;
  localparam logic [3:0] ADDR_YR_ONES   = 4'd11;
  localparam logic [3:0] ADDR_YR_TENS   = 4'd12;
  localparam logic [3:0] ADDR_MODE      = 4'd13;
  localparam logic [3:0] ADDR_TEST      = 4'd14;
  localparam logic [3:0] ADDR_RESET     = 4'd15;

  // Alarm register that carries the 24-hour select in bit 0
  localparam logic [3:0] ADDR_ALARM_H24 = 4'd10;

  // Calendar time carried with each access
  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_base;
    logic [2:0] weekday;
  } time_fields_t;

  // Bits of each alarm register that can hold a one
  function automatic logic [3:0] alarm_mask(input logic [3:0] addr);
    logic [3:0] m;
    case (addr)
      4'd0, 4'd1, 4'd9, 4'd12: m = 4'h0;
      4'd3, 4'd6:              m = 4'h7;
      4'd5, 4'd8, 4'd11:       m = 4'h3;
      ADDR_ALARM_H24:          m = 4'h1;
      default:                 m = 4'hf;
    endcase
    return m;
  endfunction

  // Tens digit by reciprocal multiply, exact for values below 128
  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

  // Ones digit as value minus ten times the tens digit
  function automatic logic [3:0] mod10(input logic [6:0] x);
    logic [6:0] q10;
    q10 = 7'(div10(x)) * 7'd10;
    return 4'(x - q10);
  endfunction

endpackage

FILE: rtl/core/rtc_bnr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module rtc_bnr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 39
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rtc_bnr_time.sv
// Time bank read decoder: turns the calendar fields into decimal digits.
// Depends on rtc_bnr_pkg.
`timescale 1ns / 1ps

module rtc_bnr_time (
  input  rtc_bnr_pkg::time_fields_t time_i,
  input  logic [3:0]                address_i,
  input  logic [3:0]                mode_i,
  input  logic                      hour24_i,
  output logic [3:0]                digit_o
);

  import rtc_bnr_pkg::*;

  logic [6:0] sec;
  logic [6:0] min;
  logic [6:0] hr;
  logic [6:0] day;
  logic [6:0] mon;
  logic [6:0] yr;
  logic [6:0] hr12;
  logic       pm;
  logic [3:0] hr_tens;

  // Widen fields; month counts from one, year folds into two digits
  always_comb begin
    sec = 7'(time_i.seconds);
    min = 7'(time_i.minutes);
    hr  = 7'(time_i.hours);
    day = 7'(time_i.day_of_month);
    mon = 7'(time_i.month_index) + 7'd1;
    if (time_i.years_since_base >= 8'd200) begin
      yr = 7'(time_i.years_since_base - 8'd200);
    end else if (time_i.years_since_base >= 8'd100) begin
      yr = 7'(time_i.years_since_base - 8'd100);
    end else begin
      yr = 7'(time_i.years_since_base);
    end
  end

  // Hour tens in 24-hour form, or 12-hour tens with the PM flag in bit 1
  always_comb begin
    pm = (hr >= 7'd12);
    if (hr >= 7'd24) begin
      hr12 = hr - 7'd24;
    end else if (pm) begin
      hr12 = hr - 7'd12;
    end else begin
      hr12 = hr;
    end
    if (hour24_i) begin
      hr_tens = div10(hr);
    end else begin
      hr_tens = {2'b00, pm, (hr12 >= 7'd10)};
    end
  end

  // Select the addressed digit
  always_comb begin
    unique case (address_i)
      ADDR_SEC_ONES: digit_o = mod10(sec);
      ADDR_SEC_TENS: digit_o = div10(sec);
      ADDR_MIN_ONES: digit_o = mod10(min);
      ADDR_MIN_TENS: digit_o = div10(min);
      ADDR_HR_ONES:  digit_o = mod10(hr);
      ADDR_HR_TENS:  digit_o = hr_tens;
      ADDR_WEEKDAY:  digit_o = 4'(time_i.weekday);
      ADDR_DAY_ONES: digit_o = mod10(day);
      ADDR_DAY_TENS: digit_o = div10(day);
      ADDR_MON_ONES: digit_o = mod10(mon);
      ADDR_MON_TENS: digit_o = div10(mon);
      ADDR_YR_ONES:  digit_o = mod10(yr);
      ADDR_YR_TENS:  digit_o = div10(yr);
      ADDR_MODE:     digit_o = mode_i;
      default:       digit_o = 4'h0;
    endcase
  end

endmodule

FILE: rtl/core/rtc_banked_nibble_registers.sv
// Top level of the banked nibble RTC register file.
// Depends on rtc_bnr_pkg, rtc_bnr_ram and rtc_bnr_time.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o): one bus access per beat, with
//   cmd, address, write nibble and the current calendar time.
//   Output channel (out_valid_o / out_stall_i): one read_data nibble per
//   access; writes return zero.
//   The low two bits of the mode register (address 13) pick the bank:
//   time digits, alarm registers, or low / high scratch nibbles.
//   Alarm and scratch nibbles live in one RAM of 3 * BANK_ENTRIES nibbles
//   with a registered read; a valid bit per entry makes unwritten entries
//   read as zero, so no clearing pass is needed after reset.
// Sequencing
//   The RAM is read at the edge that accepts the input beat and the output
//   register loads at the next edge, as the sequencer passes from ST_LOOKUP
//   to ST_OUT, where out_valid_o rises. A new access is taken at the edge
//   its predecessor's result leaves, so the block takes no new access until
//   the last result has left; ST_LOOKUP waits for the registered RAM read.
// Reset and stall
//   Reset clears the mode register, the 24-hour flag and all valid bits.
//   While out_stall_i is high the result holds and in_stall_o stays high.
//   Writes to addresses 14 and 15 are taken and discarded: never readable.

module rtc_banked_nibble_registers #(
  parameter int BANK_ENTRIES = 13
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [3:0] address_i,
  input  logic [3:0] write_data_i,
  input  logic [5:0] seconds_i,
  input  logic [5:0] minutes_i,
  input  logic [4:0] hours_i,
  input  logic [4:0] day_of_month_i,
  input  logic [3:0] month_index_i,
  input  logic [7:0] years_since_base_i,
  input  logic [2:0] weekday_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] read_data_o
);

  import rtc_bnr_pkg::*;

  localparam int RAM_DEPTH = 3 * BANK_ENTRIES;
  localparam int IDX_W     = $clog2(RAM_DEPTH);

  state_e               state_q, state_d;
  logic [3:0]           mode_q, mode_d;
  logic                 h24_q, h24_d;
  logic [RAM_DEPTH-1:0] valid_q, valid_d;
  logic                 src_ram_q, src_ram_d;
  logic                 hit_q, hit_d;
  logic [3:0]           digit_q, digit_d;
  logic [3:0]           read_data_q, read_data_d;

  logic                 in_accept;
  logic                 capture;
  logic [1:0]           bank;
  logic                 in_ram;
  logic [IDX_W-1:0]     ram_base;
  logic [IDX_W-1:0]     ram_idx;
  logic                 ram_we;
  logic                 ram_re;
  logic [3:0]           ram_wdata;
  logic [3:0]           ram_rdata;
  logic [3:0]           time_digit;
  time_fields_t         time_fields;

  // Gather the calendar fields
  assign time_fields = '{
    seconds:          seconds_i,
    minutes:          minutes_i,
    hours:            hours_i,
    day_of_month:     day_of_month_i,
    month_index:      month_index_i,
    years_since_base: years_since_base_i,
    weekday:          weekday_i
  };

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = in_valid_i ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    capture     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_LOOKUP: begin
        capture = 1'b1;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        in_stall_o  = out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  // Map bank and address onto the nibble RAM
  assign bank   = mode_q[1:0];
  assign in_ram = (bank != BANK_TIME) && (32'(address_i) < BANK_ENTRIES);

  always_comb begin
    case (bank)
      BANK_SCR_LO: ram_base = IDX_W'(BANK_ENTRIES);
      BANK_SCR_HI: ram_base = IDX_W'(2 * BANK_ENTRIES);
      default:     ram_base = '0;
    endcase
  end

  assign ram_idx = ram_base + IDX_W'(address_i);

  // Alarm writes keep only the bits each register can hold
  assign ram_wdata = (bank == BANK_ALARM) ? (write_data_i & alarm_mask(address_i))
                                          : write_data_i;
  assign ram_we    = in_accept && in_ram && (cmd_i == CMD_WRITE);
  assign ram_re    = in_accept && in_ram && (cmd_i == CMD_READ);

  rtc_bnr_ram #(
    .WIDTH (4),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_idx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_idx),
    .rdata_o (ram_rdata)
  );

  rtc_bnr_time u_time (
    .time_i    (time_fields),
    .address_i (address_i),
    .mode_i    (mode_q),
    .hour24_i  (h24_q),
    .digit_o   (time_digit)
  );

  // Update mode, the 24-hour shadow of alarm bit 0 and the valid bits
  always_comb begin
    mode_d  = mode_q;
    h24_d   = h24_q;
    valid_d = valid_q;
    if (in_accept && (cmd_i == CMD_WRITE)) begin
      if (address_i == ADDR_MODE) begin
        mode_d = write_data_i;
      end
      if ((bank == BANK_ALARM) && (address_i == ADDR_ALARM_H24)) begin
        h24_d = write_data_i[0];
      end
    end
    if (ram_we) begin
      valid_d[ram_idx] = 1'b1;
    end
  end

  // Latch the access: source of the result and the non-RAM value
  always_comb begin
    src_ram_d = src_ram_q;
    hit_d     = hit_q;
    digit_d   = digit_q;
    if (in_accept) begin
      src_ram_d = ram_re;
      hit_d     = valid_q[ram_idx];
      digit_d   = (cmd_i == CMD_READ) ? time_digit : 4'h0;
    end
  end

  // Fill the output register once RAM data is back
  always_comb begin
    read_data_d = read_data_q;
    if (capture) begin
      if (src_ram_q) begin
        read_data_d = hit_q ? ram_rdata : 4'h0;
      end else begin
        read_data_d = digit_q;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= 4'h0;
      h24_q     <= 1'b0;
      valid_q   <= '0;
      src_ram_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      h24_q     <= h24_d;
      valid_q   <= valid_d;
      src_ram_q <= src_ram_d;
      hit_q     <= hit_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    digit_q     <= digit_d;
    read_data_q <= read_data_d;
  end

  assign read_data_o = read_data_q;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for rtc_banked_nibble_registers: directed rows, then
// random bus accesses, checked against a predictor or typed-in values. Needs rtc_bnr_pkg.
`timescale 1ns / 1ps

module tb_top;
  import rtc_bnr_pkg::*;

  localparam int BANK_ENTRIES  = 13;
  localparam int RANDOM_ACCESS = 1500;
  localparam int STUCK_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;

  // One directed stimulus row; a typed-in read value overrides the predictor
  typedef struct {
    logic         wr;
    logic [3:0]   addr;
    logic [3:0]   wdata;
    time_fields_t tf;
    bit           has_lit;
    logic [3:0]   lit;
  } access_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       cmd_i;
  logic [3:0] address_i;
  logic [3:0] write_data_i;
  logic [5:0] seconds_i;
  logic [5:0] minutes_i;
  logic [4:0] hours_i;
  logic [4:0] day_of_month_i;
  logic [3:0] month_index_i;
  logic [7:0] years_since_base_i;
  logic [2:0] weekday_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [3:0] read_data_o;

  rtc_banked_nibble_registers #(
    .BANK_ENTRIES(BANK_ENTRIES)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .address_i         (address_i),
    .write_data_i      (write_data_i),
    .seconds_i         (seconds_i),
    .minutes_i         (minutes_i),
    .hours_i           (hours_i),
    .day_of_month_i    (day_of_month_i),
    .month_index_i     (month_index_i),
    .years_since_base_i(years_since_base_i),
    .weekday_i         (weekday_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .read_data_o       (read_data_o)
  );

  // Shadow copy of the register file
  logic [7:0] scratch_q [BANK_ENTRIES];
  logic [3:0] alarm_q [BANK_ENTRIES];
  logic [3:0] mode_q;
  logic [3:0] test_q;
  logic [3:0] reset_reg_q;

  logic [3:0]  read_data_q[$];
  access_row_t dir_rows[$];
  bit          cur_has_lit;
  logic [3:0]  cur_lit;
  bit          no_idle;
  int          fail_cnt = 0;
  int          stuck_cycles = 0;
  logic [3:0]  exp_rd;

  // Clock: 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Predict the nibble returned by one access and update the shadow state
  function automatic logic [3:0] rtc_predict(input logic wr, input logic [3:0] addr,
                                             input logic [3:0] wd, input time_fields_t tf);
    logic [1:0]  bank;
    logic [3:0]  rd;
    int unsigned sec, mins, hr, day, mon, yr;
    bank = mode_q[1:0];
    rd   = 4'd0;
    sec  = tf.seconds;
    mins = tf.minutes;
    hr   = tf.hours;
    day  = tf.day_of_month;
    mon  = tf.month_index + 1;
    yr   = tf.years_since_base % 100;
    if ((bank == BANK_SCR_LO || bank == BANK_SCR_HI) && addr < BANK_ENTRIES) begin
      if (wr == CMD_WRITE) begin
        if (bank == BANK_SCR_LO) scratch_q[addr][3:0] = wd;
        else scratch_q[addr][7:4] = wd;
      end else begin
        rd = (bank == BANK_SCR_LO) ? scratch_q[addr][3:0] : scratch_q[addr][7:4];
      end
    end else if (bank == BANK_ALARM && addr < BANK_ENTRIES) begin
      if (wr == CMD_WRITE) begin
        // Store, then force the fixed bits of every alarm entry low
        alarm_q[addr] = wd;
        alarm_q[0]    = 4'd0;
        alarm_q[1]    = 4'd0;
        alarm_q[9]    = 4'd0;
        alarm_q[12]   = 4'd0;
        alarm_q[3][3] = 1'b0;
        alarm_q[6][3] = 1'b0;
        alarm_q[5][3:2]  = 2'd0;
        alarm_q[8][3:2]  = 2'd0;
        alarm_q[11][3:2] = 2'd0;
        alarm_q[ADDR_ALARM_H24][3:1] = 3'd0;
      end else begin
        rd = alarm_q[addr];
      end
    end else if (wr == CMD_WRITE) begin
      case (addr)
        ADDR_MODE:  mode_q = wd;
        ADDR_TEST:  test_q = wd;
        ADDR_RESET: reset_reg_q = wd;
        default:    ;
      endcase
    end else begin
      case (addr)
        ADDR_SEC_ONES: rd = 4'(sec % 10);
        ADDR_SEC_TENS: rd = 4'(sec / 10);
        ADDR_MIN_ONES: rd = 4'(mins % 10);
        ADDR_MIN_TENS: rd = 4'(mins / 10);
        ADDR_HR_ONES:  rd = 4'(hr % 10);
        ADDR_HR_TENS: begin
          if (alarm_q[ADDR_ALARM_H24][0]) rd = 4'(hr / 10);
          else rd = 4'((hr % 12) / 10) | ((hr >= 12) ? 4'd2 : 4'd0);
        end
        ADDR_WEEKDAY:  rd = 4'(tf.weekday);
        ADDR_DAY_ONES: rd = 4'(day % 10);
        ADDR_DAY_TENS: rd = 4'(day / 10);
        ADDR_MON_ONES: rd = 4'(mon % 10);
        ADDR_MON_TENS: rd = 4'(mon / 10);
        ADDR_YR_ONES:  rd = 4'(yr % 10);
        ADDR_YR_TENS:  rd = 4'(yr / 10);
        ADDR_MODE:     rd = mode_q;
        default:       rd = 4'd0;
      endcase
    end
    return rd;
  endfunction

  function automatic bit roll_idle();
    return !no_idle && ($urandom_range(99) < 38);
  endfunction

  task automatic add_row(input logic wr, input logic [3:0] addr, input logic [3:0] wd,
                         input time_fields_t tf, input bit has_lit, input logic [3:0] lit);
    access_row_t r;
    r.wr = wr;
    r.addr = addr;
    r.wdata = wd;
    r.tf = tf;
    r.has_lit = has_lit;
    r.lit = lit;
    dir_rows.push_back(r);
  endtask

  // Present one beat at a falling edge and hold it until it is taken
  task automatic drive_access(input access_row_t r);
    while (roll_idle()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    cmd_i              <= r.wr;
    address_i          <= r.addr;
    write_data_i       <= r.wdata;
    seconds_i          <= r.tf.seconds;
    minutes_i          <= r.tf.minutes;
    hours_i            <= r.tf.hours;
    day_of_month_i     <= r.tf.day_of_month;
    month_index_i      <= r.tf.month_index;
    years_since_base_i <= r.tf.years_since_base;
    weekday_i          <= r.tf.weekday;
    cur_has_lit        <= r.has_lit;
    cur_lit            <= r.lit;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Receiver stalls at random, except in the burst stretch
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= roll_idle();
  end

  // Check each result beat, then predict each accepted access
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (read_data_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: result beat with none expected: read_data=%h", $realtime,
                     read_data_o);
        end else begin
          exp_rd = read_data_q.pop_front();
          if (read_data_o !== exp_rd) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("%0t: read_data mismatch: expected %h, got %h", $realtime,
                       exp_rd, read_data_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        exp_rd = rtc_predict(cmd_i, address_i, write_data_i,
                             '{seconds: seconds_i, minutes: minutes_i, hours: hours_i,
                               day_of_month: day_of_month_i, month_index: month_index_i,
                               years_since_base: years_since_base_i, weekday: weekday_i});
        read_data_q.push_back(cur_has_lit ? cur_lit : exp_rd);
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    time_fields_t tf_max, tf_zero, tf_pm;
    access_row_t  r;
    int           pick;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_READ;
    address_i = '0;
    write_data_i = '0;
    seconds_i = '0;
    minutes_i = '0;
    hours_i = '0;
    day_of_month_i = '0;
    month_index_i = '0;
    years_since_base_i = '0;
    weekday_i = '0;
    cur_has_lit = 1'b0;
    cur_lit = '0;
    no_idle = 1'b0;
    mode_q = '0;
    test_q = '0;
    reset_reg_q = '0;
    for (int i = 0; i < BANK_ENTRIES; i++) begin
      scratch_q[i] = '0;
      alarm_q[i] = '0;
    end

    tf_max = '1;
    tf_zero = '0;
    tf_pm = '{seconds: 6'd59, minutes: 6'd59, hours: 5'd23, day_of_month: 5'd31,
              month_index: 4'd11, years_since_base: 8'd199, weekday: 3'd6};

    // Time bank at reset, fields at their widest (out-of-range digits)
    add_row(CMD_READ, ADDR_SEC_ONES, 4'h0, tf_max, 1, 4'd3);
    add_row(CMD_READ, ADDR_SEC_TENS, 4'h0, tf_max, 1, 4'd6);
    add_row(CMD_READ, ADDR_HR_ONES, 4'h0, tf_max, 1, 4'd1);
    add_row(CMD_READ, ADDR_HR_TENS, 4'h0, tf_max, 1, 4'd2);
    add_row(CMD_READ, ADDR_HR_TENS, 4'h0, tf_zero, 1, 4'd0);
    add_row(CMD_READ, ADDR_WEEKDAY, 4'h0, tf_max, 1, 4'd7);
    add_row(CMD_READ, ADDR_MON_ONES, 4'h0, tf_max, 1, 4'd6);
    add_row(CMD_READ, ADDR_YR_TENS, 4'h0, tf_max, 1, 4'd5);
    add_row(CMD_READ, ADDR_MODE, 4'h0, tf_max, 1, 4'd0);
    // Time bank writes are dropped; test and reset registers never read back
    add_row(CMD_WRITE, ADDR_SEC_ONES, 4'hf, tf_max, 1, 4'd0);
    add_row(CMD_WRITE, ADDR_TEST, 4'hf, tf_max, 1, 4'd0);
    add_row(CMD_WRITE, ADDR_RESET, 4'hf, tf_max, 1, 4'd0);
    add_row(CMD_READ, ADDR_TEST, 4'h0, tf_max, 1, 4'd0);
    add_row(CMD_READ, ADDR_RESET, 4'h0, tf_max, 1, 4'd0);
    // Alarm bank: fixed bits clear, 24-hour select in entry 10
    add_row(CMD_WRITE, ADDR_MODE, 4'h1, tf_zero, 1, 4'd0);
    add_row(CMD_WRITE, ADDR_ALARM_H24, 4'hf, tf_zero, 1, 4'd0);
    add_row(CMD_READ, ADDR_ALARM_H24, 4'h0, tf_zero, 1, 4'd1);
    add_row(CMD_WRITE, ADDR_SEC_TENS, 4'hf, tf_zero, 0, 4'd0);
    add_row(CMD_READ, ADDR_SEC_TENS, 4'h0, tf_zero, 1, 4'd0);
    add_row(CMD_WRITE, ADDR_MODE, 4'h0, tf_pm, 1, 4'd0);
    add_row(CMD_READ, ADDR_HR_TENS, 4'h0, tf_pm, 0, 4'd0);
    // Scratch nibbles: one half written leaves the other alone
    add_row(CMD_WRITE, ADDR_MODE, 4'he, tf_pm, 1, 4'd0);
    add_row(CMD_WRITE, ADDR_YR_TENS, 4'hf, tf_pm, 1, 4'd0);
    add_row(CMD_WRITE, ADDR_MODE, 4'h3, tf_pm, 1, 4'd0);
    add_row(CMD_READ, ADDR_YR_TENS, 4'h0, tf_pm, 0, 4'd0);
    add_row(CMD_READ, ADDR_MODE, 4'h0, tf_pm, 1, 4'd3);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) drive_access(dir_rows[i]);

    // Random accesses: frequent mode writes keep all banks in play
    for (int n = 0; n < RANDOM_ACCESS; n++) begin
      no_idle = (n >= 400 && n < 600);
      // Hold off until the pipe has drained once
      if (n == 1000) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (read_data_q.size() != 0) @(negedge clk_i);
      end
      pick = $urandom_range(99);
      r.wr = (pick < 12) ? CMD_WRITE : logic'($urandom_range(1));
      r.addr = (pick < 12) ? ADDR_MODE : 4'($urandom);
      r.wdata = 4'($urandom);
      r.tf = time_fields_t'({$urandom, $urandom});
      r.has_lit = 1'b0;
      r.lit = '0;
      drive_access(r);
    end
    in_valid_i <= 1'b0;

    // Drain, then keep watching for stray beats
    while (read_data_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && read_data_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rtc_bnr_pkg.sv
rtl/core/rtc_bnr_ram.sv
rtl/core/rtc_bnr_time.sv
rtl/core/rtc_banked_nibble_registers.sv
sim/tb_top.sv
